// ===== src/tss_pkg.sv =====
// Package for the two-stack shared-memory block.
// Command and status codes, item structs. No dependencies.
`default_nettype none
package tss_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic               side;
    logic signed [31:0] value;
  } tss_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               from_side;
    logic [1:0]         status;
    logic               last;
  } tss_out_t;

endpackage
`default_nettype wire

// ===== src/two_stacks_shared_memory.sv =====
// Two stacks in one shared RAM: low stack grows up, high stack grows down.
// Depends on tss_pkg and tss_ram.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command per transfer:
//   push or pop on a side, or dump of both stacks. Output channel
//   out_valid/out_stall/out_data carries results; out_data.last marks the
//   final result of a command.
//   Push: one result, registered at the accepting edge.
//   Pop: one RAM read; the result passes the RAM read register, then the output register.
//   Dump: each stored entry is read in S_DRD and then emitted in S_DOUT;
//   an empty dump gives one result.
//   A new command is taken only when the previous one has finished, so push
//   runs at one item per cycle while out_stall does not hold the output,
//   and a pop is held in S_POP until its read data is in the output register.
//   Reset empties both stacks; RAM contents are not cleared.
//   While out_stall holds the output register, the block holds its state
//   and the RAM read data; only S_DRD still reads and moves on to S_DOUT.
`default_nettype none
module two_stacks_shared_memory
  import tss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tss_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tss_out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_DRD  = 4'b0100,
    S_DOUT = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] low_count_r, low_count_nxt;
  logic [CW-1:0] high_start_r, high_start_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          side_r, side_nxt;
  logic          out_valid_r, out_valid_nxt;
  tss_out_t      out_r, out_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  logic          out_free, in_xfer, low_empty, high_empty;

  tss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE) || !out_free;
  assign in_xfer    = in_valid && !in_stall;
  assign low_empty  = (low_count_r == '0);
  assign high_empty = (high_start_r == FULL_CNT);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    state_nxt      = state_r;
    low_count_nxt  = low_count_r;
    high_start_nxt = high_start_r;
    ptr_nxt        = ptr_r;
    side_nxt       = side_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = low_count_r[AW-1:0];
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.command)
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              out_nxt = '{data: '0, from_side: in_data.side, status: ST_OK, last: 1'b1};
              if (low_count_r >= high_start_r) begin
                out_nxt.status = ST_OVERFLOW;
              end else if (in_data.side == SIDE_LOW) begin
                ram_we        = 1'b1;
                ram_waddr     = low_count_r[AW-1:0];
                low_count_nxt = low_count_r + CW'(1);
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = AW'(high_start_r - CW'(1));
                high_start_nxt = high_start_r - CW'(1);
              end
            end
            CMD_POP: begin
              side_nxt = in_data.side;
              if ((in_data.side == SIDE_LOW) ? low_empty : high_empty) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: '0, from_side: in_data.side, status: ST_EMPTY,
                            last: 1'b1};
              end else if (in_data.side == SIDE_LOW) begin
                ram_re        = 1'b1;
                ram_raddr     = AW'(low_count_r - CW'(1));
                low_count_nxt = low_count_r - CW'(1);
                state_nxt     = S_POP;
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = high_start_r[AW-1:0];
                high_start_nxt = high_start_r + CW'(1);
                state_nxt      = S_POP;
              end
            end
            CMD_DUMP: begin
              if (low_empty && high_empty) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: '0, from_side: SIDE_LOW, status: ST_EMPTY, last: 1'b1};
              end else begin
                state_nxt = S_DRD;
                if (!low_empty) begin
                  side_nxt = SIDE_LOW;
                  ptr_nxt  = AW'(low_count_r - CW'(1));
                end else begin
                  side_nxt = SIDE_HIGH;
                  ptr_nxt  = high_start_r[AW-1:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{data: ram_rdata, from_side: side_r, status: ST_OK, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{data: ram_rdata, from_side: side_r, status: ST_OK, last: 1'b0};
          state_nxt = S_DRD;
          if (side_r == SIDE_LOW) begin
            if (ptr_r != '0) begin
              ptr_nxt = ptr_r - AW'(1);
            end else if (high_empty) begin
              out_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              side_nxt = SIDE_HIGH;
              ptr_nxt  = high_start_r[AW-1:0];
            end
          end else begin
            if (ptr_r == TOP_ADDR) begin
              out_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              ptr_nxt = ptr_r + AW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      low_count_r  <= '0;
      high_start_r <= FULL_CNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      low_count_r  <= low_count_nxt;
      high_start_r <= high_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    side_r <= side_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== src/tss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_two_stacks_shared_memory.sv =====
// Self-checking testbench for two_stacks_shared_memory (DEPTH 16).
// Holds a scoreboard class that predicts push, pop and dump results.
// Depends on tss_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_two_stacks_shared_memory;
  import tss_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_ITEMS = 470;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class stack_scoreboard;
    logic [31:0] words [DEPTH];
    logic [4:0]  low_fill;
    logic [4:0]  high_base;
    tss_out_t    pending_results [$];
    int unsigned errors, results_seen;
    int unsigned pushes, pops, dumps, ignored, overflows, empties;

    function new();
      low_fill = '0;
      high_base = 5'(DEPTH);
    endfunction

    function void add_expected(logic [31:0] data, logic side, logic [1:0] status,
                               logic last);
      tss_out_t r;
      r.data = data;
      r.from_side = side;
      r.status = status;
      r.last = last;
      if (status == ST_OVERFLOW) overflows++;
      if (status == ST_EMPTY) empties++;
      pending_results.push_back(r);
    endfunction

    function void note_command(tss_in_t cmd);
      int total;
      int k;
      case (cmd.command)
        CMD_PUSH: begin
          pushes++;
          if (low_fill >= high_base) begin
            add_expected('0, cmd.side, ST_OVERFLOW, 1'b1);
          end else begin
            if (cmd.side == SIDE_LOW) begin
              words[low_fill] = cmd.value;
              low_fill++;
            end else begin
              high_base--;
              words[high_base] = cmd.value;
            end
            add_expected('0, cmd.side, ST_OK, 1'b1);
          end
        end
        CMD_POP: begin
          pops++;
          if (cmd.side == SIDE_LOW) begin
            if (low_fill == 0) begin
              add_expected('0, SIDE_LOW, ST_EMPTY, 1'b1);
            end else begin
              low_fill--;
              add_expected(words[low_fill], SIDE_LOW, ST_OK, 1'b1);
            end
          end else begin
            if (high_base >= DEPTH) begin
              add_expected('0, SIDE_HIGH, ST_EMPTY, 1'b1);
            end else begin
              add_expected(words[high_base], SIDE_HIGH, ST_OK, 1'b1);
              high_base++;
            end
          end
        end
        CMD_DUMP: begin
          dumps++;
          total = int'(low_fill) + (DEPTH - int'(high_base));
          if (total == 0) begin
            add_expected('0, SIDE_LOW, ST_EMPTY, 1'b1);
          end else begin
            k = 0;
            for (int i = int'(low_fill); i > 0; i--) begin
              k++;
              add_expected(words[i-1], SIDE_LOW, ST_OK, k == total);
            end
            for (int i = int'(high_base); i < DEPTH; i++) begin
              k++;
              add_expected(words[i], SIDE_HIGH, ST_OK, k == total);
            end
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(tss_out_t got);
      tss_out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $error("unexpected result: data %0d from_side %0d status %0d last %0d",
               got.data, got.from_side, got.status, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got.data !== want.data) begin
        errors++;
        $error("data: expected %0d, got %0d", want.data, got.data);
      end
      if (got.from_side !== want.from_side) begin
        errors++;
        $error("from_side: expected %0d, got %0d", want.from_side, got.from_side);
      end
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tss_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tss_out_t out_data;

  stack_scoreboard sb = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned sent_items;
  int unsigned quiet_cycles;

  two_stacks_shared_memory #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // hold the payload until the transfer, then note it
  task automatic send_cmd(logic [1:0] command, logic side, logic [31:0] value);
    tss_in_t item;
    item.command = command;
    item.side = side;
    item.value = value;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_command(item);
    if (command != CMD_UNUSED) sent_items++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // fill to the meeting point, try to overflow, then list everything
  task automatic fill_until_full();
    int unsigned high_bias;
    high_bias = $urandom_range(2) * 50;
    while (sb.low_fill < sb.high_base)
      send_cmd(CMD_PUSH, $urandom_range(99) < high_bias, pick_word());
    repeat ($urandom_range(1, 2)) send_cmd(CMD_PUSH, 1'($urandom_range(1)), pick_word());
    send_cmd(CMD_DUMP, 1'($urandom_range(1)), $urandom);
  endtask

  task automatic drain_both();
    logic side;
    while (sb.low_fill != 0 || sb.high_base != DEPTH) begin
      if (sb.low_fill == 0) side = SIDE_HIGH;
      else if (sb.high_base == DEPTH) side = SIDE_LOW;
      else side = 1'($urandom_range(1));
      send_cmd(CMD_POP, side, $urandom);
    end
    send_cmd(CMD_POP, 1'($urandom_range(1)), $urandom);
    send_cmd(CMD_DUMP, 1'($urandom_range(1)), $urandom);
  endtask

  task automatic random_command();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) send_cmd(CMD_PUSH, 1'($urandom_range(1)), pick_word());
    else if (pick < 80) send_cmd(CMD_POP, 1'($urandom_range(1)), $urandom);
    else if (pick < 95) send_cmd(CMD_DUMP, 1'($urandom_range(1)), $urandom);
    else send_cmd(CMD_UNUSED, 1'($urandom_range(1)), $urandom);
  endtask

  task automatic run_traffic(int unsigned item_goal);
    int unsigned pick;
    while (sent_items < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 8) fill_until_full();
      else if (pick < 14) drain_both();
      else random_command();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent_items = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_DUMP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_POP, SIDE_LOW, 32'hffff_ffff);
    send_cmd(CMD_POP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_PUSH, SIDE_LOW, 32'h8000_0000);
    send_cmd(CMD_PUSH, SIDE_HIGH, 32'h7fff_ffff);
    send_cmd(CMD_PUSH, SIDE_LOW, 32'd10);
    send_cmd(CMD_PUSH, SIDE_HIGH, 32'hffff_ffff);
    send_cmd(CMD_PUSH, SIDE_LOW, 32'h0);
    send_cmd(CMD_UNUSED, SIDE_HIGH, 32'hffff_ffff);
    send_cmd(CMD_DUMP, SIDE_LOW, 32'h0);
    send_cmd(CMD_POP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_POP, SIDE_LOW, 32'h0);
    send_cmd(CMD_POP, SIDE_LOW, 32'h0);
    send_cmd(CMD_POP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_POP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_PUSH, SIDE_HIGH, 32'h5555_5555);
    send_cmd(CMD_PUSH, SIDE_LOW, 32'haaaa_aaaa);
    send_cmd(CMD_DUMP, SIDE_HIGH, 32'hffff_ffff);
    send_cmd(CMD_POP, SIDE_LOW, 32'h0);
    send_cmd(CMD_POP, SIDE_HIGH, 32'h0);
    send_cmd(CMD_POP, SIDE_LOW, 32'h0);
    send_cmd(CMD_POP, SIDE_LOW, 32'h8000_0000);
    send_cmd(CMD_DUMP, SIDE_LOW, 32'h0);
    wait_results_drained();

    fill_until_full();
    drain_both();
    run_traffic(130);
    wait_results_drained();

    idle_pct = 55;
    stall_pct = 0;
    run_traffic(240);
    wait_results_drained();

    idle_pct = 0;
    stall_pct = 55;
    run_traffic(350);
    wait_results_drained();

    idle_pct = 27;
    stall_pct = 27;
    run_traffic(TARGET_ITEMS);
    wait_results_drained();

    stall_pct = 0;
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("Ran %0d commands: %0d push, %0d pop, %0d dump, %0d unused code.",
             sb.pushes + sb.pops + sb.dumps + sb.ignored, sb.pushes, sb.pops,
             sb.dumps, sb.ignored);
    $display("Checked %0d results, %0d overflow and %0d empty reports among them.",
             sb.results_seen, sb.overflows, sb.empties);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== two_stacks_shared_memory.f =====
src/tss_pkg.sv
src/tss_ram.sv
src/two_stacks_shared_memory.sv
verif/tb_two_stacks_shared_memory.sv
